// ===== rtl/core/fic_pkg.sv =====
// Shared types, constants and sizing functions of the Fenwick inversion counter.
`default_nettype none

package fic_pkg;

	// Item field widths
	localparam int RANK_W  = 11;
	localparam int TOTAL_W = 27;

	// Tree counter width and sequence epoch tag width
	localparam int CNT_W   = 11;
	localparam int EPOCH_W = 3;

	localparam int MAX_RANK_DEF = 1024;

	localparam logic [TOTAL_W-1:0] TOTAL_MOD  = TOTAL_W'(100000000 - 3);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUSY,
		ST_DONE
	} state_t;

	// Control part of the token that walks down the row of cells
	typedef struct packed {
		logic               vld;
		logic               first;
		logic               pre;
		logic               upd;
		logic [EPOCH_W-1:0] epoch;
	} tok_t;

	// One stored tree counter, tagged with the sequence that wrote it
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [CNT_W-1:0]   cnt;
	} ent_t;

	// Bits that hold a tree position up to mr; also the number of tree levels
	function automatic int pos_w(int mr);
		return $clog2(mr + 1);
	endfunction

	// Positions at level lvl: odd multiples of 2**lvl up to mr
	function automatic int lvl_depth(int mr, int lvl);
		return ((mr >> lvl) + 1) >> 1;
	endfunction

	function automatic int idx_w(int d);
		return (d > 1) ? $clog2(d) : 1;
	endfunction

	// Prefix sum width: one full counter per level
	function automatic int sum_w(int mr);
		return CNT_W + $clog2(pos_w(mr) + 1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fic_in_if.sv =====
// Input channel of the Fenwick inversion counter: rank and first flag.
`default_nettype none

interface fic_in_if import fic_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;
	logic              first;

	modport source (output valid, output rank, output first, input ready);
	modport sink   (input valid, input rank, input first, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fic_out_if.sv =====
// Output channel of the Fenwick inversion counter: running total.
`default_nettype none

interface fic_out_if import fic_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] total;

	modport source (output valid, output total, input ready);
	modport sink   (input valid, input total, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fic_cell.sv =====
// One tree level: its counter memory, prefix contribution and counter update.
`default_nettype none

module fic_cell import fic_pkg::*; #(
	parameter int MAX_RANK = MAX_RANK_DEF,
	parameter int LVL      = 0
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             clr_en,
	input  wire logic [idx_w(lvl_depth(MAX_RANK, 0))-1:0]         clr_idx,
	input  wire tok_t                                             in_ctl,
	input  wire logic [pos_w(MAX_RANK)-1:0]                       in_pre_pos,
	input  wire logic [pos_w(MAX_RANK)-1:0]                       in_upd_pos,
	input  wire logic [sum_w(MAX_RANK)-1:0]                       in_acc,
	output tok_t                                                  out_ctl,
	output logic [pos_w(MAX_RANK)-1:0]                            out_pre_pos,
	output logic [pos_w(MAX_RANK)-1:0]                            out_upd_pos,
	output logic [sum_w(MAX_RANK)-1:0]                            out_acc
);

	localparam int PW    = pos_w(MAX_RANK);
	localparam int SW    = sum_w(MAX_RANK);
	localparam int D     = lvl_depth(MAX_RANK, LVL);
	localparam int AW    = idx_w(D);
	localparam int CIW   = idx_w(lvl_depth(MAX_RANK, 0));
	localparam int LMASK = (1 << LVL) - 1;
	localparam int MTOP  = MAX_RANK >> LVL;

	ent_t mem [D];

	logic [PW-1:0] p_shr;
	logic [AW-1:0] idx_p;
	logic          hit_p;
	logic [PW:0]   u_rnd;
	logic [PW:0]   u_m;
	logic [PW:0]   u_half;
	logic [AW-1:0] idx_u;
	logic          hit_u;

	tok_t          ctl_s1;
	logic [PW-1:0] p_s1;
	logic [PW-1:0] u_s1;
	logic [SW-1:0] acc_s1;
	logic          hp_s1;
	logic          hu_s1;
	logic [AW-1:0] iu_s1;
	ent_t          rdp_s1;
	ent_t          rdu_s1;

	logic [CNT_W-1:0] cnt_p;
	logic [CNT_W-1:0] cnt_u;
	logic             wr_en;
	ent_t             wr_ent;
	logic [SW-1:0]    acc_nx;

	tok_t          ctl_s2;
	logic [PW-1:0] p_s2;
	logic [PW-1:0] u_s2;
	logic [SW-1:0] acc_s2;

	// Prefix walk takes this level's counter when bit LVL of the position is set
	always_comb begin
		p_shr = in_pre_pos >> (LVL + 1);
		idx_p = p_shr[AW-1:0];
		hit_p = in_ctl.pre && in_pre_pos[LVL];
	end

	// Update walk covers the odd multiple of 2**LVL at or above the rank
	always_comb begin
		u_rnd  = {1'b0, in_upd_pos} + (PW+1)'(LMASK);
		u_m    = u_rnd >> LVL;
		u_half = u_m >> 1;
		idx_u  = u_half[AW-1:0];
		hit_u  = in_ctl.upd && u_m[0] && (u_m <= (PW+1)'(MTOP));
	end

	// Memory: clear sweep or counter write, two registered reads
	always_ff @(posedge clk) begin
		if (clr_en) begin
			if (clr_idx < CIW'(D - 1) || clr_idx == CIW'(D - 1)) begin
				mem[clr_idx[AW-1:0]] <= '0;
			end
		end else if (wr_en) begin
			mem[iu_s1] <= wr_ent;
		end
		rdp_s1 <= mem[idx_p];
		rdu_s1 <= mem[idx_u];
		p_s1   <= in_pre_pos;
		u_s1   <= in_upd_pos;
		acc_s1 <= in_acc;
		hp_s1  <= hit_p;
		hu_s1  <= hit_u;
		iu_s1  <= idx_u;
	end

	// Drop counters tagged with an older sequence, add and bump
	always_comb begin
		cnt_p  = (hp_s1 && rdp_s1.epoch == ctl_s1.epoch) ? rdp_s1.cnt : '0;
		cnt_u  = (rdu_s1.epoch == ctl_s1.epoch) ? rdu_s1.cnt : '0;
		acc_nx = acc_s1 + SW'(cnt_p);
		wr_en  = ctl_s1.vld && hu_s1;
		wr_ent = '{epoch: ctl_s1.epoch, cnt: cnt_u + CNT_W'(1)};
	end

	// Token control through both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	// Hand the token payload to the next level
	always_ff @(posedge clk) begin
		p_s2   <= p_s1;
		u_s2   <= u_s1;
		acc_s2 <= acc_nx;
	end

	assign out_ctl     = ctl_s2;
	assign out_pre_pos = p_s2;
	assign out_upd_pos = u_s2;
	assign out_acc     = acc_s2;

endmodule

`default_nettype wire

// ===== rtl/core/fenwick_inversion_counter.sv =====
// Top level of the Fenwick inversion counter: launch, row of level cells, total.
//
//  channel   dir  payload                     handshake
//  items     in   rank[10:0], first           valid / ready
//  results   out  total[26:0]                 valid / ready
//
// One item at a time walks the row of level cells, through the s1 and s2 registers
// of each level. Its total passes the launch register, the level cells, the catch
// register and the result register; ready is high again when it shows. After reset
// the counter memories are swept clear, ready low. Each first flag opens a new tagged
// sequence; every eighth one sweeps again first, which holds that item's launch back.
// A result held by a stalled consumer does not block the next accept; its total waits.
`default_nettype none

module fenwick_inversion_counter import fic_pkg::*; #(
	parameter int MAX_RANK = MAX_RANK_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fic_in_if.sink     items,
	fic_out_if.source  results
);

	localparam int PW    = pos_w(MAX_RANK);
	localparam int SW    = sum_w(MAX_RANK);
	localparam int LVLS  = PW;
	localparam int D0    = lvl_depth(MAX_RANK, 0);
	localparam int CIW   = idx_w(D0);
	localparam int CW    = (PW > RANK_W) ? PW : RANK_W;

	state_t st_q;
	state_t st_nx;

	logic in_rdy;
	logic in_fire;
	logic clr_en;
	logic clr_last;
	logic clr_done;
	logic fin_take;
	logic done_fire;
	logic need_clr;

	logic [CIW-1:0]     clr_idx_q;
	logic               pend_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [EPOCH_W-1:0] ep_nx;

	logic [CW-1:0] rank_x;
	logic [CW-1:0] p_x;
	logic [CW-1:0] p_sat;
	logic          pre_c;
	logic          upd_c;

	tok_t          lau_ctl_q;
	logic [PW-1:0] lau_p_q;
	logic [PW-1:0] lau_u_q;

	tok_t          ch_ctl [LVLS+1];
	logic [PW-1:0] ch_p   [LVLS+1];
	logic [PW-1:0] ch_u   [LVLS+1];
	logic [SW-1:0] ch_acc [LVLS+1];

	logic [SW-1:0]      fin_acc_q;
	logic               fin_first_q;
	logic [TOTAL_W-1:0] base;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W:0]   sum_red;
	logic [TOTAL_W-1:0] tot_q;
	logic               out_vld_q;

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_nx;
		end
	end

	always_comb begin
		st_nx     = st_q;
		in_rdy    = 1'b0;
		clr_en    = 1'b0;
		clr_done  = 1'b0;
		fin_take  = 1'b0;
		done_fire = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				clr_en = 1'b1;
				if (clr_last) begin
					clr_done = 1'b1;
					st_nx    = pend_q ? ST_BUSY : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (items.valid) begin
					st_nx = need_clr ? ST_CLEAR : ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (ch_ctl[LVLS].vld) begin
					fin_take = 1'b1;
					st_nx    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || results.ready) begin
					done_fire = 1'b1;
					st_nx     = ST_IDLE;
				end
			end
			default: st_nx = ST_IDLE;
		endcase
	end

	assign in_fire  = items.valid && in_rdy;
	assign clr_last = (clr_idx_q == CIW'(D0 - 1));
	assign need_clr = items.first && (epoch_q == EPOCH_LAST);
	assign ep_nx    = !items.first ? epoch_q :
	                  need_clr     ? '0 : epoch_q + EPOCH_W'(1);

	// Sweep index and epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			pend_q    <= 1'b0;
			epoch_q   <= '0;
		end else begin
			if (clr_en) begin
				clr_idx_q <= clr_last ? '0 : clr_idx_q + CIW'(1);
			end
			if (in_fire && need_clr) begin
				pend_q <= 1'b1;
			end else if (clr_done) begin
				pend_q <= 1'b0;
			end
			if (in_fire) begin
				epoch_q <= ep_nx;
			end
		end
	end

	// Turn the rank into a saturated prefix position and an update position
	always_comb begin
		rank_x = CW'(items.rank);
		pre_c  = (items.rank != '0);
		p_x    = rank_x - CW'(1);
		p_sat  = (p_x > CW'(MAX_RANK)) ? CW'(MAX_RANK) : p_x;
		upd_c  = pre_c && (rank_x <= CW'(MAX_RANK));
	end

	// Launch the token into the first level; hold it across a sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lau_ctl_q <= '0;
		end else begin
			if (in_fire) begin
				lau_ctl_q <= '{vld: !need_clr, first: items.first, pre: pre_c,
				               upd: upd_c, epoch: ep_nx};
			end else begin
				lau_ctl_q.vld <= clr_done && pend_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			lau_p_q <= p_sat[PW-1:0];
			lau_u_q <= rank_x[PW-1:0];
		end
	end

	assign ch_ctl[0] = lau_ctl_q;
	assign ch_p[0]   = lau_p_q;
	assign ch_u[0]   = lau_u_q;
	assign ch_acc[0] = '0;

	// Row of level cells
	for (genvar k = 0; k < LVLS; k++) begin : g_lvl
		fic_cell #(
			.MAX_RANK (MAX_RANK),
			.LVL      (k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.clr_en      (clr_en),
			.clr_idx     (clr_idx_q),
			.in_ctl      (ch_ctl[k]),
			.in_pre_pos  (ch_p[k]),
			.in_upd_pos  (ch_u[k]),
			.in_acc      (ch_acc[k]),
			.out_ctl     (ch_ctl[k+1]),
			.out_pre_pos (ch_p[k+1]),
			.out_upd_pos (ch_u[k+1]),
			.out_acc     (ch_acc[k+1])
		);
	end

	// Catch the finished count
	always_ff @(posedge clk) begin
		if (fin_take) begin
			fin_acc_q   <= ch_acc[LVLS];
			fin_first_q <= ch_ctl[LVLS].first;
		end
	end

	// Modular add: the sum stays below twice the modulus
	always_comb begin
		base    = fin_first_q ? '0 : tot_q;
		sum     = {1'b0, base} + (TOTAL_W+1)'(fin_acc_q);
		sum_red = (sum >= {1'b0, TOTAL_MOD}) ? sum - {1'b0, TOTAL_MOD} : sum;
	end

	// Result register, also the running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (done_fire) begin
				tot_q     <= sum_red[TOTAL_W-1:0];
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign items.ready   = in_rdy;
	assign results.valid = out_vld_q;
	assign results.total = tot_q;

endmodule

`default_nettype wire

// ===== rtl/core/fic_checker.sv =====
// Port-level checks of the Fenwick inversion counter and their binding.
`default_nettype none

module fic_checker import fic_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [TOTAL_W-1:0] total
);

	// Total is always reduced below the modulus
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total < TOTAL_MOD))
		else $error("total not reduced");

	// One item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accept while an item is in flight");

	// A new result frees the input side at once
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("input not ready when result appears");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(total)))
		else $error("stalled result changed");

endmodule

bind fenwick_inversion_counter fic_checker u_fic_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.total     (results.total)
);

`default_nettype wire
